FILE: rtl/fmapf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fmapf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int RATE_W     = 24;
  localparam int PHASE_W    = 25;
  localparam int LEVEL_W    = 18;
  localparam int EN_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_STAGE_EN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEEMPH_ALPHA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LPF_ALPHA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_IN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd5;

  localparam logic [1:0] MUL_DEEMPH = 2'd0;
  localparam logic [1:0] MUL_LPF    = 2'd1;
  localparam logic [1:0] MUL_GAIN   = 2'd2;

  localparam int EN_DEEMPH = 0;
  localparam int EN_LPF    = 1;
  localparam int EN_DC     = 2;

  typedef struct packed {
    logic [EN_W-1:0]   stage_en;
    logic [COEF_W-1:0] deemph_alpha;
    logic [COEF_W-1:0] lpf_alpha;
    logic [RATE_W-1:0] rate_in;
    logic [RATE_W-1:0] out_step;
    logic [COEF_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic       ld_in;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       upd_deemph;
    logic       upd_lpf;
    logic       upd_dc;
    logic       upd_decim;
    logic       upd_gain;
    logic       ld_out;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic emit;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/fmapf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fmapf_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  input  wire logic [fmapf_pkg::EN_W-1:0] stage_en,
  input  wire fmapf_pkg::stat_t          stat,
  output fmapf_pkg::cmd_t                cmd
);
  import fmapf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DE_MUL = 4'd1;
  localparam logic [3:0] S_DE_UPD = 4'd2;
  localparam logic [3:0] S_LP_MUL = 4'd3;
  localparam logic [3:0] S_LP_UPD = 4'd4;
  localparam logic [3:0] S_DC     = 4'd5;
  localparam logic [3:0] S_DEC    = 4'd6;
  localparam logic [3:0] S_G_MUL  = 4'd7;
  localparam logic [3:0] S_G_UPD  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_DEEMPH;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DE_MUL;
        end
      end
      S_DE_MUL: begin
        if (stage_en[EN_DEEMPH]) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_DEEMPH;
          state_nxt   = S_DE_UPD;
        end else begin
          state_nxt = S_LP_MUL;
        end
      end
      S_DE_UPD: begin
        cmd.upd_deemph = 1'b1;
        state_nxt      = S_LP_MUL;
      end
      S_LP_MUL: begin
        if (stage_en[EN_LPF]) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_LPF;
          state_nxt   = S_LP_UPD;
        end else begin
          state_nxt = S_DC;
        end
      end
      S_LP_UPD: begin
        cmd.upd_lpf = 1'b1;
        state_nxt   = S_DC;
      end
      S_DC: begin
        cmd.upd_dc = stage_en[EN_DC];
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        if (stat.bypass) begin
          state_nxt = S_OUT;
        end else begin
          cmd.upd_decim = 1'b1;
          state_nxt     = stat.emit ? S_G_MUL : S_IDLE;
        end
      end
      S_G_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
        state_nxt   = S_G_UPD;
      end
      S_G_UPD: begin
        cmd.upd_gain = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fmapf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module fmapf_dp #(
  parameter int MAX_DECIMATION = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire fmapf_pkg::cmd_t                     cmd,
  input  wire fmapf_pkg::cfg_t                     cfg,
  input  wire logic signed [fmapf_pkg::SAMPLE_W-1:0] in_audio,
  output fmapf_pkg::stat_t                         stat,
  output logic signed [fmapf_pkg::SAMPLE_W-1:0]    out_audio
);
  import fmapf_pkg::*;

  localparam int LIM    = MAX_DECIMATION * 32768;
  localparam int SUM_W  = $clog2(LIM) + 1;
  localparam int DIFF_W = LEVEL_W + 1;
  localparam int A_W    = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
  localparam int B_W    = COEF_W + 1;
  localparam int PROD_W = A_W + B_W;
  localparam logic signed [SUM_W:0] SUM_HI = (SUM_W+1)'(LIM - 1);
  localparam logic signed [SUM_W:0] SUM_LO = (SUM_W+1)'(-LIM);
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(16384);

  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] out_audio_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [LEVEL_W-1:0]  deemph_level_r;
  logic signed [LEVEL_W-1:0]  lowpass_level_r;
  logic signed [LEVEL_W-1:0]  dc_est_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [PHASE_W-1:0]         phase_r;

  logic signed [DIFF_W-1:0]   d_de, d_lp, d_sel;
  logic signed [LEVEL_W-1:0]  level_sel, level_nxt;
  logic signed [A_W-1:0]      op_a;
  logic signed [B_W-1:0]      op_b;
  logic signed [PROD_W-1:0]   p_rnd, p_shift;
  logic signed [DIFF_W-1:0]   dc_diff, dc_out;
  logic signed [LEVEL_W-1:0]  dc_nxt;
  logic signed [SAMPLE_W-1:0] dc_sat;
  logic signed [SUM_W:0]      sum_ext;
  logic signed [SUM_W-1:0]    sum_sat;
  logic [PHASE_W:0]           phase_sum;
  logic [PHASE_W-1:0]         phase_sat;

  function automatic logic [COEF_W-1:0] clamp_alpha(input logic [COEF_W-1:0] a);
    logic [COEF_W-1:0] r;
    r = a;
    if (a[COEF_W-1] && (|a[COEF_W-2:0])) begin
      r = {1'b1, {(COEF_W-1){1'b0}}};
    end
    return r;
  endfunction

  assign d_de = DIFF_W'(x_r) - DIFF_W'(deemph_level_r);
  assign d_lp = DIFF_W'(x_r) - DIFF_W'(lowpass_level_r);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_sel)
      MUL_DEEMPH: begin
        op_a = A_W'(d_de);
        op_b = $signed({1'b0, clamp_alpha(cfg.deemph_alpha)});
      end
      MUL_LPF: begin
        op_a = A_W'(d_lp);
        op_b = $signed({1'b0, clamp_alpha(cfg.lpf_alpha)});
      end
      MUL_GAIN: begin
        op_a = A_W'(sum_r);
        op_b = $signed({1'b0, cfg.gain});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    d_sel     = cmd.upd_lpf ? d_lp : d_de;
    level_sel = cmd.upd_lpf ? lowpass_level_r : deemph_level_r;
    p_rnd     = prod_r;
    if (!d_sel[DIFF_W-1] && (|d_sel)) begin
      p_rnd = prod_r + RND;
    end else if (d_sel[DIFF_W-1]) begin
      p_rnd = prod_r - RND;
    end
    p_shift   = p_rnd >>> 15;
    level_nxt = level_sel + p_shift[LEVEL_W-1:0];
  end

  always_comb begin
    dc_diff = DIFF_W'(x_r) - DIFF_W'(dc_est_r);
    dc_nxt  = dc_est_r + LEVEL_W'(dc_diff >>> 11);
    dc_out  = DIFF_W'(x_r) - DIFF_W'(dc_nxt);
    if (dc_out > DIFF_W'(32767)) begin
      dc_sat = 16'sh7fff;
    end else if (dc_out < -DIFF_W'(32768)) begin
      dc_sat = 16'sh8000;
    end else begin
      dc_sat = dc_out[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    sum_ext = (SUM_W+1)'(sum_r) + (SUM_W+1)'(x_r);
    if (sum_ext > SUM_HI) begin
      sum_sat = SUM_HI[SUM_W-1:0];
    end else if (sum_ext < SUM_LO) begin
      sum_sat = SUM_LO[SUM_W-1:0];
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
    phase_sum = {1'b0, phase_r} + (PHASE_W+1)'(cfg.out_step);
    phase_sat = phase_sum[PHASE_W] ? {PHASE_W{1'b1}} : phase_sum[PHASE_W-1:0];
  end

  assign stat.bypass = (cfg.out_step == '0);
  assign stat.emit   = (phase_sat >= PHASE_W'(cfg.rate_in));
  assign out_audio   = out_audio_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      x_r <= in_audio;
    end else if (cmd.upd_deemph || cmd.upd_lpf) begin
      x_r <= level_nxt[SAMPLE_W-1:0];
    end else if (cmd.upd_dc) begin
      x_r <= dc_sat;
    end else if (cmd.upd_gain) begin
      x_r <= prod_r[SAMPLE_W+14:15];
    end
    if (cmd.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.ld_out) begin
      out_audio_r <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deemph_level_r  <= '0;
      lowpass_level_r <= '0;
      dc_est_r        <= '0;
      sum_r           <= '0;
      phase_r         <= '0;
    end else begin
      if (cmd.upd_deemph) begin
        deemph_level_r <= level_nxt;
      end
      if (cmd.upd_lpf) begin
        lowpass_level_r <= level_nxt;
      end
      if (cmd.upd_dc) begin
        dc_est_r <= dc_nxt;
      end
      if (cmd.upd_decim) begin
        sum_r   <= sum_sat;
        phase_r <= stat.emit ? (phase_sat - PHASE_W'(cfg.rate_in)) : phase_sat;
      end else if (cmd.mul_en && (cmd.mul_sel == MUL_GAIN)) begin
        sum_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fm_audio_post_filter_chain.sv
// FM audio post-filter chain: de-emphasis, optional audio low-pass, DC blocker
// and fractional decimator, applied in that order to each incoming sample.
// The input channel (in_valid, in_stall, in_audio_in) takes one signed 16-bit
// sample per request; the result channel (out_valid, out_stall, out_audio_out)
// gives zero or one sample per input request.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle, as the block does not enforce
// it. Indexes are stage enables, de-emphasis alpha, low-pass alpha, input rate
// step, output rate step and resample gain. De-emphasis, low-pass and gain
// share one multiplier and all steps are sequenced one after another: a
// sample is accepted, each enabled one-pole stage takes a multiply and an
// update step and each disabled one a single step, then come the DC blocker
// and decimator steps, then gain multiply, gain update and output steps when
// the decimator emits, or the output step alone when it is bypassed.
// In_stall is high while a sample is in process. The output register lets the
// next sample enter while a result waits; if out_stall holds a result, the
// following result waits in the last step and the input stays stalled.
// Synchronous reset restores the default configuration and clears all filter
// levels, the decimator sum and phase, and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module fm_audio_post_filter_chain #(
  parameter int MAX_DECIMATION = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [fmapf_pkg::SAMPLE_W-1:0]  in_audio_in,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [fmapf_pkg::SAMPLE_W-1:0]     out_audio_out,
  input  wire logic                                 cfg_we,
  input  wire logic [fmapf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fmapf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fmapf_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stage_en     <= '0;
      cfg_r.deemph_alpha <= 16'd32768;
      cfg_r.lpf_alpha    <= 16'd32768;
      cfg_r.rate_in      <= 24'd48000;
      cfg_r.out_step     <= '0;
      cfg_r.gain         <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STAGE_EN:     cfg_r.stage_en     <= cfg_data[EN_W-1:0];
        REG_DEEMPH_ALPHA: cfg_r.deemph_alpha <= cfg_data[COEF_W-1:0];
        REG_LPF_ALPHA:    cfg_r.lpf_alpha    <= cfg_data[COEF_W-1:0];
        REG_RATE_IN:      cfg_r.rate_in      <= cfg_data[RATE_W-1:0];
        REG_OUT_STEP:     cfg_r.out_step     <= cfg_data[RATE_W-1:0];
        REG_GAIN:         cfg_r.gain         <= cfg_data[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fmapf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stage_en  (cfg_r.stage_en),
    .stat      (stat),
    .cmd       (cmd)
  );

  fmapf_dp #(
    .MAX_DECIMATION (MAX_DECIMATION)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .in_audio  (in_audio_in),
    .stat      (stat),
    .out_audio (out_audio_out)
  );

endmodule

`default_nettype wire
